// ----- rtl/rpe_pkg.sv -----
// Shared types, constants and tables for the radar plot to ENU transform.
`default_nettype none
package rpe_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int RANGE_BITS_DEF = 20;

  localparam int TURN_W       = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 34;
  localparam int ZW           = 34;
  localparam int SC_W         = 30;
  localparam int FRAC         = 28;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int POST_LAT     = 13;
  localparam int SC_DLY       = 10;
  localparam int QDEPTH       = 2;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_MOUNT_YAW   = 1'b0;
  localparam logic [0:0] REG_MOUNT_PITCH = 1'b1;

  // Angle slots in a turn set
  localparam int NUM_ANG = 7;
  localparam int ANG_AZ  = 0;
  localparam int ANG_EL  = 1;
  localparam int ANG_MP  = 2;
  localparam int ANG_MY  = 3;
  localparam int ANG_RL  = 4;
  localparam int ANG_PT  = 5;
  localparam int ANG_YW  = 6;

  typedef logic [TURN_W-1:0] turn_t;
  typedef turn_t [NUM_ANG-1:0] turn_set_t;

  typedef struct packed {
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] c;
  } trig_t;
  typedef trig_t [NUM_ANG-1:0] trig_set_t;

  // Arctangent of 2^-i in 32-bit turns
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

endpackage
`default_nettype wire

// ----- rtl/radar_plot_to_enu_transform.sv -----
// Radar plot to east/north/up transform, top level.
// Request path: queue, 32-stage CORDIC, 13 post stages; seven CORDIC units in parallel.
// Throughput: one request per cycle unless the output stalls; CORDIC sets the depth.
// The whole back pipeline stalls only while a result waits at the output.
// Reset clears the queue, the pipeline valid bits and both mount registers to zero.
`default_nettype none
module radar_plot_to_enu_transform
  import rpe_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_index_i,
  input  wire logic [ANGLE_BITS-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ANGLE_BITS-1:0] azimuth_i,
  input  wire logic [ANGLE_BITS-1:0] elevation_i,
  input  wire logic [RANGE_BITS-1:0] slant_range_i,
  input  wire logic [ANGLE_BITS-1:0] platform_roll_i,
  input  wire logic [ANGLE_BITS-1:0] platform_pitch_i,
  input  wire logic [ANGLE_BITS-1:0] platform_yaw_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [RANGE_BITS:0]        east_o,
  output logic [RANGE_BITS:0]        north_o,
  output logic [RANGE_BITS:0]        up_o
);

  logic                  q_valid, q_pop;
  turn_set_t             q_turns;
  logic [RANGE_BITS-1:0] q_range;

  rpe_front #(.ANGLE_BITS(ANGLE_BITS), .RANGE_BITS(RANGE_BITS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .azimuth_i        (azimuth_i),
    .elevation_i      (elevation_i),
    .slant_range_i    (slant_range_i),
    .platform_roll_i  (platform_roll_i),
    .platform_pitch_i (platform_pitch_i),
    .platform_yaw_i   (platform_yaw_i),
    .q_valid_o        (q_valid),
    .q_pop_i          (q_pop),
    .q_turns_o        (q_turns),
    .q_range_o        (q_range)
  );

  rpe_back #(.RANGE_BITS(RANGE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_turns_i   (q_turns),
    .q_range_i   (q_range),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .east_o      (east_o),
    .north_o     (north_o),
    .up_o        (up_o)
  );

endmodule
`default_nettype wire

// ----- rtl/rpe_front.sv -----
// Front end: configuration registers, angle-to-turn conversion and request queue.
`default_nettype none
module rpe_front
  import rpe_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_index_i,
  input  wire logic [ANGLE_BITS-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ANGLE_BITS-1:0] azimuth_i,
  input  wire logic [ANGLE_BITS-1:0] elevation_i,
  input  wire logic [RANGE_BITS-1:0] slant_range_i,
  input  wire logic [ANGLE_BITS-1:0] platform_roll_i,
  input  wire logic [ANGLE_BITS-1:0] platform_pitch_i,
  input  wire logic [ANGLE_BITS-1:0] platform_yaw_i,
  output logic                       q_valid_o,
  input  wire logic                  q_pop_i,
  output turn_set_t                  q_turns_o,
  output logic [RANGE_BITS-1:0]      q_range_o
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [ANGLE_BITS-1:0] mount_yaw_q, mount_pitch_q;
  turn_set_t             turns;
  turn_set_t             tq_q [QDEPTH];
  logic [RANGE_BITS-1:0] rq_q [QDEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  push, pop;

  function automatic turn_t to_turn(input logic [ANGLE_BITS-1:0] a);
    return {a, {(TURN_W-ANGLE_BITS){1'b0}}};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mount_yaw_q   <= '0;
      mount_pitch_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MOUNT_YAW:   mount_yaw_q   <= cfg_data_i;
        REG_MOUNT_PITCH: mount_pitch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Mount angles are applied negated
  always_comb begin
    turns         = '0;
    turns[ANG_AZ] = to_turn(azimuth_i);
    turns[ANG_EL] = to_turn(elevation_i);
    turns[ANG_MP] = turn_t'(0) - to_turn(mount_pitch_q);
    turns[ANG_MY] = turn_t'(0) - to_turn(mount_yaw_q);
    turns[ANG_RL] = to_turn(platform_roll_i);
    turns[ANG_PT] = to_turn(platform_pitch_i);
    turns[ANG_YW] = to_turn(platform_yaw_i);
  end

  assign in_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_turns_o  = tq_q[rd_ptr_q];
  assign q_range_o  = rq_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      tq_q[wr_ptr_q] <= turns;
      rq_q[wr_ptr_q] <= slant_range_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rpe_cordic.sv -----
// Pipelined rotation-mode CORDIC giving sine and cosine of a 32-bit turn in Q28.
`default_nettype none
module rpe_cordic
  import rpe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire turn_t  turn_i,
  output trig_t       trig_o
);

  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
  logic                 flip_q [CORDIC_STEPS+1];
  logic                 flip0;
  turn_t                tf;
  logic signed [XW-1:0] xf, yf;

  // Fold the left half-plane by pi and negate at the end
  assign flip0 = (turn_i[TURN_W-1:TURN_W-2] == 2'd1) || (turn_i[TURN_W-1:TURN_W-2] == 2'd2);
  assign tf    = flip0 ? turn_i + {1'b1, {(TURN_W-1){1'b0}}} : turn_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= XW'(CORDIC_GAIN);
      y_q[0]    <= '0;
      z_q[0]    <= $signed({{(ZW-TURN_W){tf[TURN_W-1]}}, tf});
      flip_q[0] <= flip0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign xf = flip_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
  assign yf = flip_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];

  // Round Q30 to Q28
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_o.c <= SC_W'((xf + XW'(2)) >>> 2);
      trig_o.s <= SC_W'((yf + XW'(2)) >>> 2);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rpe_rot.sv -----
// Two-stage plane rotation: registered products, then rounded sums.
`default_nettype none
module rpe_rot
  import rpe_pkg::*;
#(
  parameter int VW = RANGE_BITS_DEF + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [VW-1:0] a_i,
  input  wire logic signed [VW-1:0] b_i,
  input  wire logic signed [VW-1:0] p_i,
  input  wire trig_t                trig_i,
  output logic signed [VW-1:0]      a_o,
  output logic signed [VW-1:0]      b_o,
  output logic signed [VW-1:0]      p_o
);

  localparam int PM = VW + SC_W;
  localparam int PW = PM + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC - 1);

  logic signed [PM-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [VW-1:0] p1_q;
  logic signed [PW-1:0] sum_a, sum_b;

  function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + HALF) >>> FRAC;
    return t[VW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= PM'($signed(trig_i.c) * a_i);
      sb_q <= PM'($signed(trig_i.s) * b_i);
      sa_q <= PM'($signed(trig_i.s) * a_i);
      cb_q <= PM'($signed(trig_i.c) * b_i);
      p1_q <= p_i;
    end
  end

  assign sum_a = PW'(ca_q) - PW'(sb_q);
  assign sum_b = PW'(sa_q) + PW'(cb_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= rnd(sum_a);
      b_o <= rnd(sum_b);
      p_o <= p1_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rpe_back.sv -----
// Back end: sine/cosine units, projection, rotation chain and output register.
`default_nettype none
module rpe_back
  import rpe_pkg::*;
#(
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  output logic                       q_pop_o,
  input  wire turn_set_t             q_turns_i,
  input  wire logic [RANGE_BITS-1:0] q_range_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [RANGE_BITS:0]        east_o,
  output logic [RANGE_BITS:0]        north_o,
  output logic [RANGE_BITS:0]        up_o
);

  localparam int VW  = RANGE_BITS + 2;
  localparam int PM  = VW + SC_W;
  localparam int LAT = CORDIC_LAT + POST_LAT;
  localparam logic signed [PM-1:0] HALF = PM'(1) << (FRAC - 1);
  localparam logic signed [VW-1:0] LIM  = VW'((65'sd1 <<< RANGE_BITS) - 65'sd1);

  logic                  en;
  logic [LAT-1:0]        vld_q;
  logic [RANGE_BITS-1:0] rd_q [CORDIC_LAT];
  trig_set_t             trig;
  trig_set_t             sc_q [SC_DLY];
  logic signed [VW-1:0]  rv;
  logic signed [VW-1:0]  h_q, p1v1_q, v0_q, v1_q, v2_q;
  logic signed [VW-1:0]  r0a, r0b, r0p, r1a, r1b, r1p;
  logic signed [VW-1:0]  r2a, r2b, r2p, r3a, r3b, r3p, r4a, r4b, r4p;
  logic signed [VW-1:0]  up_v;

  function automatic logic signed [VW-1:0] rnd(input logic signed [PM-1:0] v);
    logic signed [PM-1:0] t;
    t = (v + HALF) >>> FRAC;
    return t[VW-1:0];
  endfunction

  function automatic logic [RANGE_BITS:0] sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    if (v > LIM)       t = LIM;
    else if (v < -LIM) t = -LIM;
    else               t = v;
    return t[RANGE_BITS:0];
  endfunction

  // Whole pipeline advances unless a finished result is stuck
  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], q_valid_i};
    end
  end

  for (genvar k = 0; k < NUM_ANG; k++) begin : g_trig
    rpe_cordic u_cordic (
      .clk_i  (clk_i),
      .en_i   (en),
      .turn_i (q_turns_i[k]),
      .trig_o (trig[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[0] <= q_range_i;
      for (int i = 1; i < CORDIC_LAT; i++) rd_q[i] <= rd_q[i-1];
      sc_q[0] <= trig;
      for (int i = 1; i < SC_DLY; i++) sc_q[i] <= sc_q[i-1];
    end
  end

  assign rv = $signed({2'b00, rd_q[CORDIC_LAT-1]});

  // Radar frame projection over two stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q    <= rnd(PM'(rv * $signed(trig[ANG_EL].c)));
      p1v1_q <= rnd(PM'(rv * $signed(trig[ANG_EL].s)));
      v0_q   <= rnd(PM'(h_q * $signed(sc_q[0][ANG_AZ].s)));
      v1_q   <= p1v1_q;
      v2_q   <= rnd(PM'(h_q * $signed(sc_q[0][ANG_AZ].c)));
    end
  end

  // Installation: pitch about X, then yaw about Y
  rpe_rot #(.VW(VW)) u_rot_mp (
    .clk_i(clk_i), .en_i(en), .a_i(v1_q), .b_i(v2_q), .p_i(v0_q),
    .trig_i(sc_q[1][ANG_MP]), .a_o(r0a), .b_o(r0b), .p_o(r0p)
  );
  rpe_rot #(.VW(VW)) u_rot_my (
    .clk_i(clk_i), .en_i(en), .a_i(r0b), .b_i(r0p), .p_i(r0a),
    .trig_i(sc_q[3][ANG_MY]), .a_o(r1a), .b_o(r1b), .p_o(r1p)
  );
  // LUF to FRD: t0 = v2, t1 = -v0, t2 = -v1; roll about X on (t1, t2)
  rpe_rot #(.VW(VW)) u_rot_rl (
    .clk_i(clk_i), .en_i(en), .a_i(-r1b), .b_i(-r1p), .p_i(r1a),
    .trig_i(sc_q[5][ANG_RL]), .a_o(r2a), .b_o(r2b), .p_o(r2p)
  );
  rpe_rot #(.VW(VW)) u_rot_pt (
    .clk_i(clk_i), .en_i(en), .a_i(r2b), .b_i(r2p), .p_i(r2a),
    .trig_i(sc_q[7][ANG_PT]), .a_o(r3a), .b_o(r3b), .p_o(r3p)
  );
  rpe_rot #(.VW(VW)) u_rot_yw (
    .clk_i(clk_i), .en_i(en), .a_i(r3b), .b_i(r3p), .p_i(r3a),
    .trig_i(sc_q[9][ANG_YW]), .a_o(r4a), .b_o(r4b), .p_o(r4p)
  );

  // NED to ENU: east = t1, north = t0, up = -t2
  assign up_v = -r4p;

  always_ff @(posedge clk_i) begin
    if (en) begin
      east_o  <= sat(r4b);
      north_o <= sat(r4a);
      up_o    <= sat(up_v);
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop from empty queue");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved while stalled");
  a_result_arrives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[LAT-2] |=> out_valid_o) else $error("result lost before output");

endmodule
`default_nettype wire
